### src/multichannel_servo_slew_controller_defines.svh
// Assertion macros shared by the servo slew controller modules.
`ifndef MULTICHANNEL_SERVO_SLEW_CONTROLLER_DEFINES_SVH
`define MULTICHANNEL_SERVO_SLEW_CONTROLLER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define MSSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define MSSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### src/mssc_pkg.sv
// Package with types and constants of the servo slew controller.
`default_nettype none
package mssc_pkg;
  localparam int unsigned Channels = 12;
  localparam int unsigned ChW = 4;
  localparam logic [7:0] AngleFull = 8'd180;
  localparam logic [11:0] PulseMinReset = 12'd102;
  localparam logic [11:0] PulseMaxReset = 12'd512;
  localparam logic [0:0] RegPulseMin = 1'b0;
  // Reciprocal of 180 scaled by 2 to the 28th, exact for 20-bit products.
  localparam logic [20:0] PulseRecip = 21'd1491309;

  typedef enum logic [2:0] {
    CmdSetRamp = 3'd0, CmdSetNow = 3'd1, CmdTick = 3'd2, CmdStop = 3'd3,
    CmdHome = 3'd4, CmdCal = 3'd5, CmdCfg = 3'd6, CmdStatus = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle, StRead, StMul, StDiv, StEmit
  } state_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic mul;
    logic div;
    logic emit;
    logic next;
  } ctrl_t;

  typedef struct packed {
    logic bulk;
    logic last_ch;
  } stat_t;
endpackage
`default_nettype wire

### src/mssc_ctrl.sv
// Controller state machine that sequences the servo datapath.
`default_nettype none
`include "multichannel_servo_slew_controller_defines.svh"
module mssc_ctrl import mssc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o,
  output logic       busy_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (start_i) state_d = StRead;
      StRead: state_d = StMul;
      StMul: state_d = StDiv;
      StDiv: state_d = StEmit;
      StEmit: state_d = (stat_i.bulk && !stat_i.last_ch) ? StRead : StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.load = (state_q == StIdle) && start_i;
    case (state_q)
      StRead: ctrl_o.rd = 1'b1;
      StMul: ctrl_o.mul = 1'b1;
      StDiv: ctrl_o.div = 1'b1;
      StEmit: begin
        ctrl_o.emit = 1'b1;
        ctrl_o.next = 1'b1;
      end
      default: ctrl_o.rd = 1'b0;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  `MSSC_ASSERT_NEXT(a_read_to_mul, clk_i, rst_ni, state_q == StRead, state_q == StMul,
    "read must be followed by multiply")
  `MSSC_ASSERT_IMP(a_load_idle, clk_i, rst_ni, ctrl_o.load, !busy_o,
    "load only while idle")
  `MSSC_ASSERT_NEXT(a_emit_leave, clk_i, rst_ni, state_q == StEmit && !stat_i.bulk,
    state_q == StIdle, "single result must end the command")
endmodule
`default_nettype wire

### src/mssc_dp.sv
// Datapath with channel state, update logic and pulse mapping.
`default_nettype none
`include "multichannel_servo_slew_controller_defines.svh"
module mssc_dp import mssc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctrl_t       ctrl_i,
  output stat_t            stat_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic [2:0]  command_i,
  input  wire logic [3:0]  channel_i,
  input  wire logic [7:0]  angle_i,
  input  wire logic [7:0]  step_size_i,
  input  wire logic [7:0]  min_angle_i,
  input  wire logic [7:0]  max_angle_i,
  input  wire logic [7:0]  home_angle_i,
  input  wire logic [3:0]  field_mask_i,
  input  wire logic        enable_i,
  input  wire logic        enable_present_i,
  output logic             valid_o,
  output logic [3:0]       out_channel_o,
  output logic [7:0]       current_angle_o,
  output logic [7:0]       target_angle_o,
  output logic             moving_o,
  output logic             enabled_o,
  output logic [11:0]      pulse_count_o,
  output logic             pulse_write_o,
  output logic             status_o,
  output logic             last_o
);
  logic [11:0] pmin_q, pmax_q;
  logic [7:0] cur_q [Channels];
  logic [7:0] tgt_q [Channels];
  logic [7:0] home_q [Channels];
  logic [7:0] lo_q [Channels];
  logic [7:0] hi_q [Channels];
  logic [7:0] stp_q [Channels];
  logic [Channels-1:0] mov_q, en_q;

  cmd_e cmd_q;
  logic [3:0] ch_q, idx_q;
  logic [7:0] ang_q, stps_q, mina_q, maxa_q, homea_q;
  logic [3:0] mask_q;
  logic en_in_q, enp_q;
  logic bulk;
  logic bad_ch, bad_ang;
  logic [7:0] c, t, lo, hi, s1, clamp, a_sel, new_cur;
  logic m, e, w;
  logic [7:0] r_cur_q, r_tgt_q;
  logic r_mov_q, r_en_q, r_w_q, r_st_q, r_bad_q;
  logic [19:0] prod_q;
  logic neg_q;
  logic signed [12:0] span;
  logic [11:0] span_abs;
  logic [39:0] recip;
  logic [11:0] quo;
  logic [7:0] ang_r;
  logic [11:0] pulse_q;
  logic [3:0] sel;

  function automatic logic [7:0] sat(input logic [7:0] v);
    sat = (v > AngleFull) ? AngleFull : v;
  endfunction

  assign bulk = (cmd_q == CmdTick) || (cmd_q == CmdStop) || (cmd_q == CmdHome)
             || (cmd_q == CmdStatus);
  assign sel = bulk ? idx_q : ch_q;
  assign bad_ch = !bulk && (ch_q >= 4'(Channels));
  assign bad_ang = (cmd_q == CmdSetRamp || cmd_q == CmdSetNow) && (ang_q > AngleFull);
  assign stat_o.bulk = bulk;
  assign stat_o.last_ch = (idx_q == 4'(Channels - 1));

  always_comb begin
    c = cur_q[sel[3:0] < 4'(Channels) ? sel : '0];
    t = tgt_q[sel[3:0] < 4'(Channels) ? sel : '0];
    lo = lo_q[sel[3:0] < 4'(Channels) ? sel : '0];
    hi = hi_q[sel[3:0] < 4'(Channels) ? sel : '0];
    s1 = stp_q[sel[3:0] < 4'(Channels) ? sel : '0];
    m = mov_q[sel[3:0] < 4'(Channels) ? sel : '0];
    e = en_q[sel[3:0] < 4'(Channels) ? sel : '0];
    if (s1 == 8'd0) s1 = 8'd1;
    a_sel = (cmd_q == CmdHome) ? home_q[sel[3:0] < 4'(Channels) ? sel : '0] : ang_q;
    clamp = (a_sel < lo) ? lo : ((a_sel > hi) ? hi : a_sel);
    if (c < t) new_cur = (9'(c) + 9'(s1) > 9'(t)) ? t : c + s1;
    else new_cur = (9'(c) < 9'(t) + 9'(s1)) ? t : c - s1;
    w = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmin_q <= PulseMinReset;
      pmax_q <= PulseMaxReset;
      for (int i = 0; i < Channels; i++) begin
        cur_q[i] <= 8'd90;
        tgt_q[i] <= 8'd90;
        home_q[i] <= 8'd90;
        lo_q[i] <= (i == 5 || i == 6) ? 8'd30 : 8'd0;
        hi_q[i] <= (i == 5 || i == 6) ? 8'd150 : AngleFull;
        stp_q[i] <= (i == 5 || i == 6) ? 8'd1 : 8'd2;
      end
      mov_q <= '0;
      en_q <= '1;
      idx_q <= '0;
      cmd_q <= CmdStatus;
      valid_o <= 1'b0;
      r_cur_q <= '0; r_tgt_q <= '0; r_mov_q <= 1'b0; r_en_q <= 1'b0;
      r_w_q <= 1'b0; r_st_q <= 1'b0; r_bad_q <= 1'b0;
    end else begin
      valid_o <= ctrl_i.emit;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegPulseMin) pmin_q <= cfg_data_i;
        else pmax_q <= cfg_data_i;
      end
      if (ctrl_i.load) begin
        cmd_q <= cmd_e'(command_i);
        idx_q <= '0;
      end
      if (ctrl_i.next) idx_q <= idx_q + 4'd1;
      if (ctrl_i.rd) begin
        r_cur_q <= c; r_tgt_q <= t; r_mov_q <= m; r_en_q <= e;
        r_w_q <= 1'b0; r_st_q <= 1'b0; r_bad_q <= bad_ch;
        if (bad_ch) begin
          r_st_q <= 1'b1;
        end else begin
          case (cmd_q)
            CmdTick: if (m && e && c != t) begin
              cur_q[sel] <= new_cur; r_cur_q <= new_cur; r_w_q <= 1'b1;
              if (new_cur == t) begin
                mov_q[sel] <= 1'b0; r_mov_q <= 1'b0;
              end
            end
            CmdStop: begin
              mov_q[sel] <= 1'b0; r_mov_q <= 1'b0;
              tgt_q[sel] <= c; r_tgt_q <= c;
            end
            CmdHome: if (e) begin
              tgt_q[sel] <= clamp; r_tgt_q <= clamp;
              mov_q[sel] <= (c != clamp); r_mov_q <= (c != clamp);
            end
            CmdSetRamp, CmdSetNow: begin
              if (bad_ang) r_st_q <= 1'b1;
              else begin
                if (mask_q[3]) stp_q[sel] <= stps_q;
                if (e && cmd_q == CmdSetRamp) begin
                  tgt_q[sel] <= clamp; r_tgt_q <= clamp;
                  mov_q[sel] <= (c != clamp); r_mov_q <= (c != clamp);
                end else if (e) begin
                  cur_q[sel] <= clamp; tgt_q[sel] <= clamp; mov_q[sel] <= 1'b0;
                  r_cur_q <= clamp; r_tgt_q <= clamp; r_mov_q <= 1'b0;
                  r_w_q <= 1'b1;
                end
              end
            end
            CmdCal: begin
              if (mask_q[0]) lo_q[sel] <= sat(mina_q);
              if (mask_q[1]) hi_q[sel] <= sat(maxa_q);
              if (mask_q[2]) home_q[sel] <= sat(homea_q);
              if (mask_q[3]) stp_q[sel] <= stps_q;
            end
            CmdCfg: begin
              if (enp_q) begin
                en_q[sel] <= en_in_q; r_en_q <= en_in_q;
              end
              if (mask_q[3]) stp_q[sel] <= stps_q;
            end
            default: r_w_q <= w;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      ch_q <= channel_i; ang_q <= angle_i; stps_q <= step_size_i;
      mina_q <= min_angle_i; maxa_q <= max_angle_i; homea_q <= home_angle_i;
      mask_q <= field_mask_i; en_in_q <= enable_i; enp_q <= enable_present_i;
    end
    if (ctrl_i.mul) begin
      prod_q <= 20'(r_cur_q) * 20'(span_abs);
      neg_q <= span[12];
    end
    if (ctrl_i.div) pulse_q <= neg_q ? pmin_q - quo : pmin_q + quo;
    if (ctrl_i.emit) begin
      out_channel_o <= sel;
      current_angle_o <= r_bad_q ? 8'd0 : r_cur_q;
      target_angle_o <= r_bad_q ? 8'd0 : r_tgt_q;
      moving_o <= r_bad_q ? 1'b0 : r_mov_q;
      enabled_o <= r_bad_q ? 1'b0 : r_en_q;
      pulse_count_o <= r_bad_q ? 12'd0 : pulse_q;
      pulse_write_o <= r_bad_q ? 1'b0 : r_w_q;
      status_o <= r_st_q;
      last_o <= !bulk || (idx_q == 4'(Channels - 1));
    end
  end

  assign span = $signed({1'b0, pmax_q}) - $signed({1'b0, pmin_q});
  assign span_abs = span[12] ? 12'(-span) : span[11:0];
  assign ang_r = r_cur_q;
  assign recip = 40'(prod_q) * 40'(PulseRecip);
  assign quo = recip[39:28];

  `MSSC_ASSERT_IMP(a_emit_follows_div, clk_i, rst_ni, ctrl_i.emit,
    $past(ctrl_i.div), "emit without preceding divide step")
  `MSSC_ASSERT_IMP(a_idx_range, clk_i, rst_ni, ctrl_i.rd && bulk,
    idx_q < 4'(Channels), "channel walk past last channel")
  `MSSC_ASSERT_IMP(a_angle_range, clk_i, rst_ni, valid_o && !status_o,
    current_angle_o <= AngleFull && ang_r <= AngleFull, "angle out of range")
endmodule
`default_nettype wire

### src/multichannel_servo_slew_controller.sv
// Top level of the multichannel servo slew controller.
`default_nettype none
// Usage: a command word is taken when start is high and busy low; its
// fields are sampled then. Configuration writes (cfg_we_i, cfg_idx_i,
// cfg_data_i) set the pulse range; the user must make them only while
// busy is low, and the block itself does not enforce this. Each result
// word is shown for one cycle with result_valid_o high; the receiver
// cannot stall, so words are never held. Single-channel commands give one
// word. Tick, stop, home and status walk all twelve channels, one word
// each. Every channel passes through the read, multiply, divide and
// output steps in turn. After reset every channel sits at 90 degrees,
// enabled and still, with default limits and a pulse range of 102 to 512.
// The last word of each command carries last_o.
module multichannel_servo_slew_controller import mssc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic [2:0]  command_i,
  input  wire logic [3:0]  channel_i,
  input  wire logic [7:0]  angle_i,
  input  wire logic [7:0]  step_size_i,
  input  wire logic [7:0]  min_angle_i,
  input  wire logic [7:0]  max_angle_i,
  input  wire logic [7:0]  home_angle_i,
  input  wire logic [3:0]  field_mask_i,
  input  wire logic        enable_i,
  input  wire logic        enable_present_i,
  output logic             result_valid_o,
  output logic [3:0]       out_channel_o,
  output logic [7:0]       current_angle_o,
  output logic [7:0]       target_angle_o,
  output logic             moving_o,
  output logic             enabled_o,
  output logic [11:0]      pulse_count_o,
  output logic             pulse_write_o,
  output logic             status_o,
  output logic             last_o
);
  ctrl_t ctrl;
  stat_t stat;

  mssc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .stat_i(stat), .ctrl_o(ctrl), .busy_o(busy)
  );

  mssc_dp u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .command_i, .channel_i, .angle_i, .step_size_i, .min_angle_i, .max_angle_i,
    .home_angle_i, .field_mask_i, .enable_i, .enable_present_i,
    .valid_o(result_valid_o), .out_channel_o, .current_angle_o, .target_angle_o,
    .moving_o, .enabled_o, .pulse_count_o, .pulse_write_o, .status_o, .last_o
  );
endmodule
`default_nettype wire
